// ----- hdl/trte_pkg.sv -----
package trte_pkg;

  // Table geometry
  localparam int unsigned CONNECTIONS = 64;
  localparam int unsigned ADDR_W      = $clog2(CONNECTIONS);
  localparam int unsigned TIMERS      = 5;
  localparam int unsigned MAX_SHIFT   = 12;

  // Tick period and the reciprocal used to turn milliseconds into ticks
  localparam int unsigned TICK_MS     = 10;
  localparam int unsigned MS_W        = 21;
  localparam int unsigned DIV_SH      = 21;
  localparam int unsigned RECIP_W     = 22;
  localparam int unsigned TICK_RECIP  = (1 << DIV_SH) / TICK_MS;

  // Field widths
  localparam int unsigned CONN_W = 6;
  localparam int unsigned SEL_W  = 3;
  localparam int unsigned RTT_W  = 16;
  localparam int unsigned TICK_W = 16;
  localparam int unsigned SRTT_W = 20;
  localparam int unsigned SHF_W  = 4;
  localparam int unsigned GRAN_W = 10;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_SAMPLE = 3'd1,
    ACT_ARM    = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CFG_GRAN    = 2'd0,
    CFG_RTO_MIN = 2'd1,
    CFG_RTO_MAX = 2'd2,
    CFG_DEF_RTO = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [GRAN_W-1:0] gran;
    logic [TICK_W-1:0] rto_min;
    logic [TICK_W-1:0] rto_max;
    logic [TICK_W-1:0] def_rto;
  } cfg_t;

  typedef struct packed {
    logic [RTT_W-1:0]  rtt;
    logic [SRTT_W-1:0] rttvar;
    logic [SRTT_W-1:0] srtt;
  } rto_req_t;

  typedef struct packed {
    logic [TICK_W-1:0] rto;
    logic [SRTT_W-1:0] rttvar;
    logic [SRTT_W-1:0] srtt;
  } rto_rsp_t;

  // One connection row: all timers plus the estimator state
  typedef struct packed {
    logic [TIMERS-1:0][TICK_W-1:0] timers;
    logic [SHF_W-1:0]              shift;
    logic [TICK_W-1:0]             rto;
    logic [SRTT_W-1:0]             rttvar;
    logic [SRTT_W-1:0]             srtt;
  } entry_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic                  at_limit;
    logic [TICK_W-1:0]     rto;
    logic [SHF_W-1:0]      backoff;
    logic                  due;
    logic [TIMERS-1:0]     mask;
    logic [CONN_W-1:0]     conn;
  } result_t;

  // Backoff multiplier per shift
  function automatic logic [6:0] backoff_scale(input logic [SHF_W-1:0] shift);
    logic [6:0] m;
    case (shift)
      4'd0:    m = 7'd1;
      4'd1:    m = 7'd2;
      4'd2:    m = 7'd4;
      4'd3:    m = 7'd8;
      4'd4:    m = 7'd16;
      4'd5:    m = 7'd32;
      default: m = 7'd64;
    endcase
    return m;
  endfunction

endpackage

// ----- hdl/trte_rto_calc.sv -----
module trte_rto_calc (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  trte_pkg::rto_req_t req_i,
  input  trte_pkg::cfg_t     cfg_i,
  output logic               done_o,
  output trte_pkg::rto_rsp_t rsp_o
);
  import trte_pkg::*;

  // Stage 1: estimator update and RTO in milliseconds
  logic [16:0]       srtt_sc;
  logic [17:0]       delta;
  logic [17:0]       mag;
  logic [SRTT_W:0]   srtt_sum;
  logic [SRTT_W-1:0] srtt_n;
  logic [SRTT_W-1:0] var_n;
  logic [SRTT_W-1:0] var_term;
  logic [MS_W-1:0]   ms_n;

  always_comb begin
    srtt_sc  = req_i.srtt[SRTT_W-1:3];
    delta    = {2'b00, req_i.rtt} - {1'b0, srtt_sc};
    mag      = delta[17] ? (18'd0 - delta) : delta;
    srtt_sum = {1'b0, req_i.srtt} + {{3{delta[17]}}, delta};
    if (req_i.srtt == '0) begin
      srtt_n = {1'b0, req_i.rtt, 3'b000};
      var_n  = {3'b000, req_i.rtt, 1'b0};
    end else begin
      srtt_n = srtt_sum[SRTT_W-1:0];
      var_n  = req_i.rttvar + {2'b00, mag} - {2'b00, req_i.rttvar[SRTT_W-1:2]};
    end
    var_term = (var_n > {10'd0, cfg_i.gran}) ? var_n : {10'd0, cfg_i.gran};
    ms_n     = {4'd0, srtt_n[SRTT_W-1:3]} + {1'b0, var_term};
  end

  logic                      v1_q, v2_q, v3_q;
  logic [SRTT_W-1:0]         srtt1_q, var1_q, srtt2_q, var2_q, srtt3_q, var3_q;
  logic [MS_W-1:0]           ms1_q, ms2_q, ms3_q;
  logic [MS_W+RECIP_W-1:0]   prod_q;
  logic [MS_W-1:0]           q0_q;
  logic [MS_W-1:0]           qt_q;
  logic [MS_W-1:0]           q0_c;
  logic [MS_W+9:0]           qt_c;

  assign q0_c = prod_q[DIV_SH +: MS_W];
  assign qt_c = {10'd0, q0_c} * (MS_W+10)'(TICK_MS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    srtt1_q <= srtt_n;
    var1_q  <= var_n;
    ms1_q   <= ms_n;
    // multiply by the reciprocal of the tick period
    prod_q  <= {{RECIP_W{1'b0}}, ms1_q} * (MS_W+RECIP_W)'(TICK_RECIP);
    srtt2_q <= srtt1_q;
    var2_q  <= var1_q;
    ms2_q   <= ms1_q;
    q0_q    <= q0_c;
    qt_q    <= qt_c[MS_W-1:0];
    srtt3_q <= srtt2_q;
    var3_q  <= var2_q;
    ms3_q   <= ms2_q;
  end

  // Stage 4: one-step quotient correction, then clamp
  logic [MS_W-1:0] rem;
  logic [MS_W-1:0] ticks;

  always_comb begin
    rem   = ms3_q - qt_q;
    ticks = (rem >= MS_W'(TICK_MS)) ? (q0_q + MS_W'(1)) : q0_q;
    if (ticks < {5'd0, cfg_i.rto_min}) begin
      rsp_o.rto = cfg_i.rto_min;
    end else if (ticks > {5'd0, cfg_i.rto_max}) begin
      rsp_o.rto = cfg_i.rto_max;
    end else begin
      rsp_o.rto = ticks[TICK_W-1:0];
    end
    rsp_o.srtt   = srtt3_q;
    rsp_o.rttvar = var3_q;
  end

  assign done_o = v3_q;

endmodule

// ----- hdl/tcp_retransmit_timer_engine.sv -----
// Tick, arm, stop and clear-backoff requests go from acceptance through the table read and
// the execute state to the output register; an RTT sample also passes the ms-to-ticks
// pipeline first. One request is in flight at a time: a new one is taken only in the idle
// state, after the last one has written its row back and its result has reached the output.
// Reset: row valid bits clear the whole table at once (rows read as zero until written),
// configuration returns to its defaults; no clearing pass, requests are taken at once.
module tcp_retransmit_timer_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // connection[5:0], timer_select[8:6], rtt_ms[24:9]
  input  logic [2:0]  s_axis_tuser,  // action[2:0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // connection_echo[5:0], expired_mask[10:6],
                                     // retransmit_due[11], backoff_count[15:12],
                                     // rto_ticks[31:16], backoff_at_limit[32]
);
  import trte_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RTO,
    ST_HOLD
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gran    <= 10'd10;
      cfg_q.rto_min <= 16'd20;
      cfg_q.rto_max <= 16'd6400;
      cfg_q.def_rto <= 16'd300;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRAN:    cfg_q.gran    <= cfg_data_i[GRAN_W-1:0];
        CFG_RTO_MIN: cfg_q.rto_min <= cfg_data_i;
        CFG_RTO_MAX: cfg_q.rto_max <= cfg_data_i;
        CFG_DEF_RTO: cfg_q.def_rto <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Request capture
  // ---------------------------------------------------------------------------
  state_e              state_q;
  logic                in_acc;
  logic [CONN_W-1:0]   in_conn;
  logic [2:0]          act_q;
  logic [CONN_W-1:0]   conn_q;
  logic [SEL_W-1:0]    sel_q;
  logic [RTT_W-1:0]    rtt_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_conn       = s_axis_tdata[CONN_W-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= s_axis_tuser;
      conn_q <= in_conn;
      sel_q  <= s_axis_tdata[8:6];
      rtt_q  <= s_axis_tdata[24:9];
    end
  end

  // ---------------------------------------------------------------------------
  // Connection table: one row per connection, read on acceptance, written back once
  // ---------------------------------------------------------------------------
  entry_t                 mem [CONNECTIONS];
  logic [CONNECTIONS-1:0] row_vld_q;
  entry_t                 rd_q;
  logic                   rd_vld_q;
  entry_t                 entry;
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  entry_t                 wr_data;

  assign wr_addr = conn_q[ADDR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= mem[in_conn[ADDR_W-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        rd_vld_q <= row_vld_q[in_conn[ADDR_W-1:0]];
      end
      if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  // A row never written reads as all zero: no sample, timers inactive
  assign entry = rd_vld_q ? rd_q : '0;

  // ---------------------------------------------------------------------------
  // Row update for tick, arm, stop and clear
  // ---------------------------------------------------------------------------
  function automatic logic [TICK_W-1:0] scaled_reload(input logic [TICK_W-1:0] base,
                                                      input logic [SHF_W-1:0]  shift,
                                                      input logic [TICK_W-1:0] cap);
    logic [22:0] prod;
    prod = 23'(base) * 23'(backoff_scale(shift));
    return (prod > {7'd0, cap}) ? cap : prod[TICK_W-1:0];
  endfunction

  logic              oor;
  logic              is_sample;
  entry_t            ent_new;
  logic [TIMERS-1:0] exp_mask;
  logic              due;
  logic              at_limit;

  assign oor       = ({1'b0, conn_q} >= (CONN_W+1)'(CONNECTIONS));
  assign is_sample = (act_q == ACT_SAMPLE);

  always_comb begin
    logic [TICK_W-1:0] base;
    logic [TICK_W-1:0] arm_val;
    ent_new  = entry;
    exp_mask = '0;
    due      = 1'b0;
    at_limit = 1'b0;
    base     = (entry.rto != '0) ? entry.rto : cfg_q.def_rto;
    arm_val  = entry.rto;
    case (act_q)
      ACT_TICK: begin
        for (int t = 0; t < TIMERS; t++) begin
          if (entry.timers[t] != '0) begin
            ent_new.timers[t] = entry.timers[t] - TICK_W'(1);
            if (entry.timers[t] == TICK_W'(1)) begin
              exp_mask[t] = 1'b1;
              if (t == 0) begin
                // bump the backoff, saturate and flag at the limit
                if (entry.shift >= SHF_W'(MAX_SHIFT)) begin
                  ent_new.shift = SHF_W'(MAX_SHIFT);
                  at_limit      = 1'b1;
                end else begin
                  ent_new.shift = entry.shift + SHF_W'(1);
                end
                ent_new.timers[t] = scaled_reload(base, ent_new.shift, cfg_q.rto_max);
                due               = 1'b1;
              end
            end
          end
        end
      end
      ACT_ARM: begin
        if ({1'b0, sel_q} < (SEL_W+1)'(TIMERS)) begin
          if (sel_q == '0 && entry.shift != '0) begin
            arm_val = scaled_reload(entry.rto, entry.shift, cfg_q.rto_max);
          end
          ent_new.timers[sel_q] = arm_val;
        end
      end
      ACT_STOP: begin
        if ({1'b0, sel_q} < (SEL_W+1)'(TIMERS)) begin
          ent_new.timers[sel_q] = '0;
        end
      end
      ACT_CLEAR: begin
        ent_new.shift = '0;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // RTT sample path
  // ---------------------------------------------------------------------------
  rto_req_t rto_req;
  rto_rsp_t rto_rsp;
  logic     rto_start;
  logic     rto_done;
  entry_t   ent_rto;

  assign rto_req.srtt   = entry.srtt;
  assign rto_req.rttvar = entry.rttvar;
  assign rto_req.rtt    = rtt_q;
  assign rto_start      = (state_q == ST_EXEC) && is_sample && !oor;

  trte_rto_calc u_rto_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rto_start),
    .req_i   (rto_req),
    .cfg_i   (cfg_q),
    .done_o  (rto_done),
    .rsp_o   (rto_rsp)
  );

  always_comb begin
    ent_rto        = entry;
    ent_rto.srtt   = rto_rsp.srtt;
    ent_rto.rttvar = rto_rsp.rttvar;
    ent_rto.rto    = rto_rsp.rto;
  end

  // ---------------------------------------------------------------------------
  // Completion, write-back and result
  // ---------------------------------------------------------------------------
  logic    finish;
  logic    out_free;
  logic    out_load;
  result_t res;
  result_t hold_q;
  result_t out_q;
  logic    out_vld_q;

  assign finish   = ((state_q == ST_EXEC) && !rto_start) || ((state_q == ST_RTO) && rto_done);
  assign out_free = !out_vld_q || m_axis_tready;
  assign out_load = out_free && (finish || (state_q == ST_HOLD));
  assign wr_en    = finish && !oor;
  assign wr_data  = (state_q == ST_RTO) ? ent_rto : ent_new;

  always_comb begin
    res.conn = conn_q;
    if (oor) begin
      res.mask     = '0;
      res.due      = 1'b0;
      res.backoff  = '0;
      res.rto      = '0;
      res.at_limit = 1'b0;
    end else begin
      res.mask     = exp_mask;
      res.due      = due;
      res.backoff  = wr_data.shift;
      res.rto      = wr_data.rto;
      res.at_limit = at_limit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      out_q     <= '0;
      hold_q    <= '0;
    end else begin
      // raise valid when a result lands in the output, drop it once the sink takes it
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC, ST_RTO: begin
          if (rto_start) begin
            state_q <= ST_RTO;
          end else if (finish) begin
            // hand the result straight to the output, or park it behind a stalled one
            if (out_free) begin
              out_q   <= res;
              state_q <= ST_IDLE;
            end else begin
              hold_q  <= res;
              state_q <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_q   <= hold_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, out_q};

`ifndef NO_ASSERTIONS
  // one request in flight: nothing is taken right after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> !s_axis_tready)
    else $error("request accepted while previous one still in flight");

  // the table is only written while a request is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> (state_q != ST_IDLE))
    else $error("table write outside a request");

  // a retransmit report implies the retransmit timer expired
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_vld_q |-> (!out_q.due || out_q.mask[0]))
    else $error("retransmit due without retransmit expiry");

  // the limit flag only rides on a retransmit expiry at full backoff
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_vld_q && out_q.at_limit |-> out_q.due &&
                   (out_q.backoff == SHF_W'(MAX_SHIFT)))
    else $error("backoff limit flag without saturated retransmit");

  // stored backoff never passes its ceiling
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   wr_en |-> (wr_data.shift <= SHF_W'(MAX_SHIFT)))
    else $error("backoff shift beyond limit");
`endif

endmodule
